@@ rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg - shared types and constants for the stable priority queue
// Sizes, operation and status codes, entry record and cell control.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  localparam int CAPACITY       = 16;
  localparam int PRIORITY_WIDTH = 16;
  localparam int TAG_WIDTH      = 16;

  // count runs 0..CAPACITY inclusive
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  // stream payload widths, padded to whole bytes
  localparam int S_DATA_BITS = PRIORITY_WIDTH + 3 * TAG_WIDTH;
  localparam int S_DATA_W    = ((S_DATA_BITS + 7) / 8) * 8;
  localparam int M_DATA_BITS = PRIORITY_WIDTH + 3 * TAG_WIDTH + COUNT_W + 1;
  localparam int M_DATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [PRIORITY_WIDTH-1:0] pri;
    logic [TAG_WIDTH-1:0]             effect;
    logic [TAG_WIDTH-1:0]             source;
    logic [TAG_WIDTH-1:0]             target;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell - one slot of the sorted shift-register queue
// Holds one entry; on push it keeps, takes the new entry or shifts from the
// left neighbor; on pop it takes the right neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    new_entry,
  input  wire entry_t    left_entry,
  input  wire logic      left_ge,
  input  wire entry_t    right_entry,
  input  wire logic      occupied,
  output entry_t         entry,
  output logic           ge
);

  entry_t entry_next;

  // held entry ranks at or above the new one (equal stays ahead)
  assign ge = occupied && ($signed(entry.pri) >= $signed(new_entry.pri));

  // slot update
  always_comb begin
    entry_next = entry;
    if (ctl.push) begin
      if (!ge) begin
        entry_next = left_ge ? new_entry : left_entry;
      end
    end else if (ctl.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

`default_nettype wire

@@ rtl/stable_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue_unit - bounded stable priority queue
// Row of sorted cells, highest priority in cell 0, older first among equals.
// ----------------------------------------------------------------------------
// Result: one per request, registered on m_tdata in the cycle after acceptance.
// Throughput: one request per cycle while the result register is free or taken by
//   m_tready; every cell updates from its neighbors in parallel, so the row compare and shift sets the pace.
// Reset: clears the entry count and the output valid; slot contents are not
//   cleared and are only read below the count.
`default_nettype none

module stable_priority_queue_unit
  import spq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,  // priority_req, effect_tag, source_tag, target_tag
  input  wire logic [1:0]          s_tuser,  // func
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,  // out_priority, out_effect, out_source,
                                             // out_target, entry_count, is_empty
  output logic [1:0]               m_tuser   // status
);

  logic [COUNT_W-1:0] held_count;
  logic [COUNT_W-1:0] held_count_next;
  logic               accept;
  op_t                op;
  logic               full;
  logic               empty;
  cell_ctl_t          ctl;
  entry_t             new_entry;
  entry_t             front;
  entry_t             res_entry;
  status_t            res_status;
  entry_t             cell_entry [CAPACITY];
  logic               cell_ge    [CAPACITY];

  // handshake: output register frees up when taken
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = op_t'(s_tuser);
  assign full     = (held_count == COUNT_W'(CAPACITY));
  assign empty    = (held_count == '0);

  // request payload unpack
  assign new_entry.pri    = s_tdata[PRIORITY_WIDTH-1:0];
  assign new_entry.effect = s_tdata[PRIORITY_WIDTH +: TAG_WIDTH];
  assign new_entry.source = s_tdata[PRIORITY_WIDTH + TAG_WIDTH +: TAG_WIDTH];
  assign new_entry.target = s_tdata[PRIORITY_WIDTH + 2 * TAG_WIDTH +: TAG_WIDTH];

  // cell commands, gated against full and empty
  assign ctl.push = accept && (op == OP_PUSH) && !full;
  assign ctl.pop  = accept && (op == OP_POP) && !empty;

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    logic   left_g;
    entry_t right_e;
    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_g = 1'b1;
    end else begin : g_body
      assign left_e = cell_entry[i-1];
      assign left_g = cell_ge[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = cell_entry[i];
    end else begin : g_inner
      assign right_e = cell_entry[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_ge     (left_g),
      .right_entry (right_e),
      .occupied    (held_count > COUNT_W'(i)),
      .entry       (cell_entry[i]),
      .ge          (cell_ge[i])
    );
  end

  assign front = cell_entry[0];

  // count, status and returned entry
  always_comb begin
    held_count_next = held_count;
    res_status      = ST_OK;
    res_entry       = '0;
    case (op)
      OP_PUSH: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          held_count_next = held_count + COUNT_W'(1);
        end
      end
      OP_POP, OP_PEEK: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_entry = front;
          if (op == OP_POP) begin
            held_count_next = held_count - COUNT_W'(1);
          end
        end
      end
      OP_CLEAR: begin
        held_count_next = '0;
      end
      default: begin
        held_count_next = held_count;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (accept) begin
        held_count <= held_count_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= res_status;
      m_tdata <= M_DATA_W'({(held_count_next == '0), held_count_next,
                            res_entry.target, res_entry.source,
                            res_entry.effect, res_entry.pri});
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (op == OP_CLEAR) |=> held_count == '0)
    else $error("clear left entries behind");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |=> held_count == $past(held_count) - COUNT_W'(1))
    else $error("pop did not drop one entry");

  a_front_sorted: assert property (@(posedge clk) disable iff (rst)
    held_count >= COUNT_W'(2) |-> $signed(cell_entry[0].pri) >= $signed(cell_entry[1].pri))
    else $error("head cells out of order");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[M_DATA_BITS-1]
                 == (m_tdata[M_DATA_BITS-2 -: COUNT_W] == '0))
    else $error("empty flag disagrees with count");

endmodule

`default_nettype wire
